// ----- sv/qrs_pkg.sv -----
// Quadratic root solver: shared types and constants.
// No dependencies; imported by qrs_root_if and the top level.
package qrs_pkg;

    localparam int ROOT_BITS  = 34;
    localparam int KIND_WIDTH = 3;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_NONE   = 3'd0,
        KIND_LINEAR = 3'd1,
        KIND_TWO    = 3'd2,
        KIND_REPEAT = 3'd3,
        KIND_NOREAL = 3'd4
    } root_kind_t;

endpackage

// ----- sv/qrs_coef_if.sv -----
// Coefficient channel: valid/ready handshake carrying a, b and c.
// Depends on nothing but its width parameter.
interface qrs_coef_if #(
    parameter int COEF_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

// ----- sv/qrs_root_if.sv -----
// Root channel: valid/ready handshake carrying the kind and both roots.
// Depends on qrs_pkg.
interface qrs_root_if;
    import qrs_pkg::*;

    logic                        valid;
    logic                        ready;
    root_kind_t                  root_kind;
    logic signed [ROOT_BITS-1:0] root_high;
    logic signed [ROOT_BITS-1:0] root_low;

    modport source (output valid, output root_kind, output root_high, output root_low,
                    input ready);
    modport sink   (input valid, input root_kind, input root_high, input root_low,
                    output ready);
endinterface

// ----- sv/quadratic_root_solver_top.sv -----
// Quadratic root solver top level: products, classification, division and root rows.
// Depends on qrs_pkg, qrs_coef_if, qrs_root_if, qrs_div_chain, qrs_sqrt_chain.
//
// Solves a*x^2 + b*x + c = 0 for one coefficient set per clock. Each beat on
// coefs yields one beat on roots with the equation kind and up to two real
// roots in signed fixed point with FRAC_BITS fraction bits (square roots
// floored, quotients truncated toward zero). A set passes stage 1, stage 2,
// the c/a pre-divider row, the square-root row, stage 3, the final divider
// row and the output register; the three rows are made of bit cells.
// A new set is taken every cycle; the whole pipe holds
// only while a result sits unclaimed in the output register.
module quadratic_root_solver_top #(
    parameter int COEF_WIDTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input logic       clk,
    input logic       rst_n,
    qrs_coef_if.sink  coefs,
    qrs_root_if.source roots
);
    import qrs_pkg::*;

    localparam int W      = COEF_WIDTH;
    localparam int PW     = 2 * W;
    localparam int DSW    = 2 * W + 3;
    localparam int DISCW  = 2 * W + 1;
    localparam int PRE_NW = W + 2 * FRAC_BITS;
    localparam int RB     = W + FRAC_BITS + 1;
    localparam int NW     = W + FRAC_BITS + 2;
    localparam int NSW    = NW + 1;
    localparam int DW     = W + 1;
    localparam int SBX    = KIND_WIDTH + 5 + 3 * W;
    localparam int SBA    = SBX + DISCW;
    localparam int SB1    = KIND_WIDTH + 1;

    logic adv;
    logic out_valid_reg;
    root_kind_t out_kind_reg;
    logic signed [ROOT_BITS-1:0] out_high_reg, out_low_reg;

    assign adv         = !out_valid_reg || roots.ready;
    assign coefs.ready = adv;

    // stage 1: products and magnitudes
    logic                s1_valid_reg;
    logic signed [PW-1:0] p_reg, ac_reg;
    logic [W-1:0]        ma_reg, mb_reg, mc_reg;
    logic                an_reg, bn_reg, cn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= coefs.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg  <= PW'(coefs.coef_b) * PW'(coefs.coef_b);
            ac_reg <= PW'(coefs.coef_a) * PW'(coefs.coef_c);
            ma_reg <= coefs.coef_a[W-1] ? W'(-coefs.coef_a) : W'(coefs.coef_a);
            mb_reg <= coefs.coef_b[W-1] ? W'(-coefs.coef_b) : W'(coefs.coef_b);
            mc_reg <= coefs.coef_c[W-1] ? W'(-coefs.coef_c) : W'(coefs.coef_c);
            an_reg <= coefs.coef_a[W-1];
            bn_reg <= coefs.coef_b[W-1];
            cn_reg <= coefs.coef_c[W-1];
        end
    end

    // stage 2: discriminant and classification
    logic signed [DSW-1:0] disc;
    root_kind_t            kind_next;
    logic                  s2_valid_reg;
    logic [DISCW-1:0]      disc_reg;
    logic [SBX-1:0]        x_reg;

    always_comb
    begin
        disc = DSW'(p_reg) - (DSW'(ac_reg) <<< 2);
        if (ma_reg == '0)
        begin
            kind_next = (mb_reg == '0) ? KIND_NONE : KIND_LINEAR;
        end
        else if (disc[DSW-1])
        begin
            kind_next = KIND_NOREAL;
        end
        else if (disc == '0)
        begin
            kind_next = KIND_REPEAT;
        end
        else
        begin
            kind_next = KIND_TWO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            disc_reg <= disc[DISCW-1:0];
            x_reg    <= {kind_next, (mb_reg == '0), (mc_reg == '0), an_reg, bn_reg, cn_reg,
                         ma_reg, mb_reg, mc_reg};
        end
    end

    // pre-divider: floor(|c| * 2^2F / |a|) for the pure quadratic
    logic [PRE_NW-1:0] pre_num;
    logic              pa_valid;
    logic [PRE_NW-1:0] pa_quot;
    logic [SBA-1:0]    pa_sb;
    logic [DISCW-1:0]  pa_disc;
    logic [SBX-1:0]    pa_x;

    assign pre_num = PRE_NW'(x_reg[W-1:0]) << (2 * FRAC_BITS);

    qrs_div_chain #(
        .NUMW (PRE_NW),
        .DENW (W),
        .SBW  (SBA)
    ) u_pre_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s2_valid_reg),
        .in_num    (pre_num),
        .in_den    (x_reg[3*W-1:2*W]),
        .in_sb     ({disc_reg, x_reg}),
        .out_valid (pa_valid),
        .out_quot  (pa_quot),
        .out_sb    (pa_sb)
    );

    assign {pa_disc, pa_x} = pa_sb;

    // square-root row
    logic [2*RB-1:0] rad;
    logic            sq_valid;
    logic [RB-1:0]   sq_root;
    logic [SBX-1:0]  sq_x;

    assign rad = pa_x[3*W+4] ? (2*RB)'(pa_quot) : ((2*RB)'(pa_disc) << (2 * FRAC_BITS));

    qrs_sqrt_chain #(
        .RB  (RB),
        .SBW (SBX)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (pa_valid),
        .in_rad    (rad),
        .in_sb     (pa_x),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_sb    (sq_x)
    );

    // stage 3: numerators, divisor and signs per kind
    logic [KIND_WIDTH-1:0] x_kind;
    logic                  x_bz, x_cz, x_an, x_bn, x_cn;
    logic [W-1:0]          x_ma, x_mb, x_mc;
    logic signed [NSW-1:0] base, n1, n2;
    logic [NW-1:0]         num1_next, num2_next;
    logic [DW-1:0]         den_next;
    logic                  neg1_next, neg2_next;

    assign {x_kind, x_bz, x_cz, x_an, x_bn, x_cn, x_ma, x_mb, x_mc} = sq_x;

    always_comb
    begin
        base      = x_bn ? signed'(NSW'(x_mb) << FRAC_BITS)
                         : -signed'(NSW'(x_mb) << FRAC_BITS);
        n1        = base + signed'(NSW'(sq_root));
        n2        = base - signed'(NSW'(sq_root));
        num1_next = '0;
        num2_next = '0;
        den_next  = DW'(1);
        neg1_next = 1'b0;
        neg2_next = 1'b0;
        unique case (root_kind_t'(x_kind))
            KIND_LINEAR:
            begin
                num1_next = NW'(x_mc) << FRAC_BITS;
                den_next  = DW'(x_mb);
                neg1_next = !x_cz && (x_cn == x_bn);
            end
            KIND_REPEAT:
            begin
                num1_next = NW'(x_mb) << FRAC_BITS;
                den_next  = {x_ma, 1'b0};
                neg1_next = !x_bz && (x_bn == x_an);
            end
            KIND_TWO:
            begin
                if (x_bz)
                begin
                    num1_next = NW'(sq_root);
                    num2_next = NW'(sq_root);
                    neg2_next = 1'b1;
                end
                else
                begin
                    num1_next = n1[NSW-1] ? NW'(-n1) : NW'(n1);
                    num2_next = n2[NSW-1] ? NW'(-n2) : NW'(n2);
                    den_next  = {x_ma, 1'b0};
                    neg1_next = (n1 != '0) && (n1[NSW-1] != x_an);
                    neg2_next = (n2 != '0) && (n2[NSW-1] != x_an);
                end
            end
            default:
            begin
                num1_next = '0;
            end
        endcase
    end

    logic                  s3_valid_reg;
    logic [NW-1:0]         num1_reg, num2_reg;
    logic [DW-1:0]         den_reg;
    logic                  neg1_reg, neg2_reg;
    logic [KIND_WIDTH-1:0] kind3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num1_reg  <= num1_next;
            num2_reg  <= num2_next;
            den_reg   <= den_next;
            neg1_reg  <= neg1_next;
            neg2_reg  <= neg2_next;
            kind3_reg <= x_kind;
        end
    end

    // final divider rows, one per root
    logic          d1_valid, d2_valid;
    logic [NW-1:0] q1, q2;
    logic [SB1-1:0] d1_sb;
    logic          d2_neg;

    qrs_div_chain #(
        .NUMW (NW),
        .DENW (DW),
        .SBW  (SB1)
    ) u_div_high (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s3_valid_reg),
        .in_num    (num1_reg),
        .in_den    (den_reg),
        .in_sb     ({kind3_reg, neg1_reg}),
        .out_valid (d1_valid),
        .out_quot  (q1),
        .out_sb    (d1_sb)
    );

    qrs_div_chain #(
        .NUMW (NW),
        .DENW (DW),
        .SBW  (1)
    ) u_div_low (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s3_valid_reg),
        .in_num    (num2_reg),
        .in_den    (den_reg),
        .in_sb     (neg2_reg),
        .out_valid (d2_valid),
        .out_quot  (q2),
        .out_sb    (d2_neg)
    );

    // output register
    root_kind_t            fin_kind;
    logic signed [NSW-1:0] q1s, q2s;
    logic signed [ROOT_BITS-1:0] high_next, low_next;

    always_comb
    begin
        fin_kind  = root_kind_t'(d1_sb[SB1-1:1]);
        q1s       = d1_sb[0] ? -signed'({1'b0, q1}) : signed'({1'b0, q1});
        q2s       = d2_neg ? -signed'({1'b0, q2}) : signed'({1'b0, q2});
        high_next = '0;
        low_next  = '0;
        unique case (fin_kind)
            KIND_LINEAR, KIND_REPEAT:
            begin
                high_next = ROOT_BITS'(q1s);
            end
            KIND_TWO:
            begin
                high_next = ROOT_BITS'(q1s);
                low_next  = ROOT_BITS'(q2s);
            end
            default:
            begin
                high_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_kind_reg <= fin_kind;
            out_high_reg <= high_next;
            out_low_reg  <= low_next;
        end
    end

    assign roots.valid     = out_valid_reg;
    assign roots.root_kind = out_kind_reg;
    assign roots.root_high = out_high_reg;
    assign roots.root_low  = out_low_reg;

    a_rows_aligned : assert property (@(posedge clk) disable iff (!rst_n)
        d1_valid == d2_valid)
        else $error("final divider rows out of step");

    a_hold_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s1_valid_reg) && $stable(s3_valid_reg))
        else $error("pipe advanced during stall");

    a_single_root : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_kind_reg == KIND_LINEAR || out_kind_reg == KIND_REPEAT ||
                          out_kind_reg == KIND_NONE || out_kind_reg == KIND_NOREAL)
        |-> out_low_reg == '0)
        else $error("second root set for single-root kind");
endmodule

// ----- sv/qrs_div_cell.sv -----
// One restoring-division cell: resolves one quotient bit per beat.
// No package dependencies; instantiated by qrs_div_chain.
module qrs_div_cell #(
    parameter int NUMW = 16,
    parameter int DENW = 16,
    parameter int SBW  = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [DENW-1:0] in_rem,
    input  logic [NUMW-1:0] in_num,
    input  logic [DENW-1:0] in_den,
    input  logic [SBW-1:0]  in_sb,
    output logic            out_valid,
    output logic [DENW-1:0] out_rem,
    output logic [NUMW-1:0] out_num,
    output logic [DENW-1:0] out_den,
    output logic [SBW-1:0]  out_sb
);
    logic            valid_reg;
    logic [DENW-1:0] rem_reg, rem_next;
    logic [NUMW-1:0] num_reg, num_next;
    logic [DENW-1:0] den_reg;
    logic [SBW-1:0]  sb_reg;
    logic [DENW:0]   shifted;
    logic [DENW+1:0] trial;
    logic            take;

    always_comb
    begin
        shifted  = {in_rem, in_num[NUMW-1]};
        trial    = {1'b0, shifted} - {2'b00, in_den};
        take     = !trial[DENW+1];
        rem_next = take ? trial[DENW-1:0] : shifted[DENW-1:0];
        num_next = {in_num[NUMW-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg <= rem_next;
            num_reg <= num_next;
            den_reg <= in_den;
            sb_reg  <= in_sb;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_sb    = sb_reg;
endmodule

// ----- sv/qrs_div_chain.sv -----
// Row of division cells giving an unsigned truncated quotient, one bit per cell.
// Depends on qrs_div_cell.
module qrs_div_chain #(
    parameter int NUMW = 16,
    parameter int DENW = 16,
    parameter int SBW  = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [NUMW-1:0] in_num,
    input  logic [DENW-1:0] in_den,
    input  logic [SBW-1:0]  in_sb,
    output logic            out_valid,
    output logic [NUMW-1:0] out_quot,
    output logic [SBW-1:0]  out_sb
);
    logic            v_link   [0:NUMW];
    logic [DENW-1:0] rem_link [0:NUMW];
    logic [NUMW-1:0] num_link [0:NUMW];
    logic [DENW-1:0] den_link [0:NUMW];
    logic [SBW-1:0]  sb_link  [0:NUMW];

    assign v_link[0]   = in_valid;
    assign rem_link[0] = '0;
    assign num_link[0] = in_num;
    assign den_link[0] = in_den;
    assign sb_link[0]  = in_sb;

    for (genvar i = 0; i < NUMW; i++)
    begin : g_cell
        qrs_div_cell #(
            .NUMW (NUMW),
            .DENW (DENW),
            .SBW  (SBW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (v_link[i]),
            .in_rem    (rem_link[i]),
            .in_num    (num_link[i]),
            .in_den    (den_link[i]),
            .in_sb     (sb_link[i]),
            .out_valid (v_link[i+1]),
            .out_rem   (rem_link[i+1]),
            .out_num   (num_link[i+1]),
            .out_den   (den_link[i+1]),
            .out_sb    (sb_link[i+1])
        );
    end

    assign out_valid = v_link[NUMW];
    assign out_quot  = num_link[NUMW];
    assign out_sb    = sb_link[NUMW];
endmodule

// ----- sv/qrs_sqrt_cell.sv -----
// One integer square-root cell: resolves one root bit from two radicand bits.
// No package dependencies; instantiated by qrs_sqrt_chain.
module qrs_sqrt_cell #(
    parameter int RB  = 16,
    parameter int SBW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [RB:0]     in_rem,
    input  logic [2*RB-1:0] in_rad,
    input  logic [RB-1:0]   in_root,
    input  logic [SBW-1:0]  in_sb,
    output logic            out_valid,
    output logic [RB:0]     out_rem,
    output logic [2*RB-1:0] out_rad,
    output logic [RB-1:0]   out_root,
    output logic [SBW-1:0]  out_sb
);
    logic            valid_reg;
    logic [RB:0]     rem_reg, rem_next;
    logic [2*RB-1:0] rad_reg;
    logic [RB-1:0]   root_reg, root_next;
    logic [SBW-1:0]  sb_reg;
    logic [RB+2:0]   shifted;
    logic [RB+3:0]   trial;
    logic            take;

    always_comb
    begin
        shifted   = {in_rem, in_rad[2*RB-1:2*RB-2]};
        trial     = {1'b0, shifted} - {2'b00, in_root, 2'b01};
        take      = !trial[RB+3];
        rem_next  = take ? trial[RB:0] : shifted[RB:0];
        root_next = {in_root[RB-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg  <= rem_next;
            rad_reg  <= {in_rad[2*RB-3:0], 2'b00};
            root_reg <= root_next;
            sb_reg   <= in_sb;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_rad   = rad_reg;
    assign out_root  = root_reg;
    assign out_sb    = sb_reg;
endmodule

// ----- sv/qrs_sqrt_chain.sv -----
// Row of square-root cells giving floor(sqrt(radicand)), one root bit per cell.
// Depends on qrs_sqrt_cell.
module qrs_sqrt_chain #(
    parameter int RB  = 16,
    parameter int SBW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [2*RB-1:0] in_rad,
    input  logic [SBW-1:0]  in_sb,
    output logic            out_valid,
    output logic [RB-1:0]   out_root,
    output logic [SBW-1:0]  out_sb
);
    logic            v_link    [0:RB];
    logic [RB:0]     rem_link  [0:RB];
    logic [2*RB-1:0] rad_link  [0:RB];
    logic [RB-1:0]   root_link [0:RB];
    logic [SBW-1:0]  sb_link   [0:RB];

    assign v_link[0]    = in_valid;
    assign rem_link[0]  = '0;
    assign rad_link[0]  = in_rad;
    assign root_link[0] = '0;
    assign sb_link[0]   = in_sb;

    for (genvar i = 0; i < RB; i++)
    begin : g_cell
        qrs_sqrt_cell #(
            .RB  (RB),
            .SBW (SBW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (v_link[i]),
            .in_rem    (rem_link[i]),
            .in_rad    (rad_link[i]),
            .in_root   (root_link[i]),
            .in_sb     (sb_link[i]),
            .out_valid (v_link[i+1]),
            .out_rem   (rem_link[i+1]),
            .out_rad   (rad_link[i+1]),
            .out_root  (root_link[i+1]),
            .out_sb    (sb_link[i+1])
        );
    end

    assign out_valid = v_link[RB];
    assign out_root  = root_link[RB];
    assign out_sb    = sb_link[RB];
endmodule

// ----- tb/sv/quadratic_root_solver_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench for quadratic_root_solver_top: random and directed coefficient sets,
// each checked against an in-bench predictor of kind and roots.
// Depends on qrs_pkg, qrs_coef_if, qrs_root_if and the solver RTL.
module quadratic_root_solver_top_tb;
    import qrs_pkg::*;

    localparam int CW        = 16;
    localparam int FB        = 16;
    localparam int LATENCY   = 119;
    localparam int WATCHDOG  = 5000;
    localparam int N_RANDOM  = 1630;
    localparam int HOLD_OFF  = 300;

    typedef struct packed {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
    } coef_set_t;

    typedef struct packed {
        root_kind_t                  kind;
        logic signed [ROOT_BITS-1:0] hi;
        logic signed [ROOT_BITS-1:0] lo;
    } root_set_t;

    logic clk;
    logic rst_n;

    qrs_coef_if #(.COEF_WIDTH(CW)) coefs ();
    qrs_root_if roots ();

    quadratic_root_solver_top #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .coefs (coefs.sink),
        .roots (roots.source)
    );

    coef_set_t pending_sets[$];
    root_set_t expected_roots[$];
    int        errors = 0;
    int        idle_cycles = 0;
    int        n_sent = 0;
    int        n_checked = 0;
    int        kind_seen[5];
    bit        hold_active;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Floor of sqrt(n) for up to 128-bit n.
    function automatic logic [127:0] isqrt(input logic [127:0] n);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            t = r | (128'd1 << i);
            if (t * t <= n)
                r = t;
        end
        return r;
    endfunction

    function automatic root_set_t solve_roots(input coef_set_t s);
        root_set_t       res;
        longint          a;
        longint          b;
        longint          c;
        longint          disc;
        longint          sq;
        longint          num;
        logic [127:0]    radicand;
        a = s.a;
        b = s.b;
        c = s.c;
        res.kind = KIND_NONE;
        res.hi   = '0;
        res.lo   = '0;
        if (a == 0)
        begin
            if (b != 0)
            begin
                res.kind = KIND_LINEAR;
                res.hi   = ROOT_BITS'((-c * (64'sd1 <<< FB)) / b);
            end
        end
        else
        begin
            disc = b * b - 4 * a * c;
            if (disc < 0)
            begin
                res.kind = KIND_NOREAL;
            end
            else if (disc == 0)
            begin
                res.kind = KIND_REPEAT;
                res.hi   = ROOT_BITS'((-b * (64'sd1 <<< FB)) / (2 * a));
            end
            else if (b == 0)
            begin
                // floor(sqrt(-c/a) * 2^F) = largest r with r*r*|a| <= |c|*2^2F
                radicand = (128'(c < 0 ? -c : c) << (2 * FB)) / 128'(a < 0 ? -a : a);
                sq       = longint'(isqrt(radicand));
                res.kind = KIND_TWO;
                res.hi   = ROOT_BITS'(sq);
                res.lo   = ROOT_BITS'(-sq);
            end
            else
            begin
                sq       = longint'(isqrt(128'(disc) << (2 * FB)));
                num      = -b * (64'sd1 <<< FB);
                res.kind = KIND_TWO;
                res.hi   = ROOT_BITS'((num + sq) / (2 * a));
                res.lo   = ROOT_BITS'((num - sq) / (2 * a));
            end
        end
        return res;
    endfunction

    function automatic logic signed [CW-1:0] pick_coef();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CW'($urandom_range(0, 6)) - CW'(3);
            2:       return {1'b1, {(CW-1){1'b0}}};
            3:       return {1'b0, {(CW-1){1'b1}}};
            4:       return CW'($urandom_range(0, 400)) - CW'(200);
            default: return CW'($urandom);
        endcase
    endfunction

    // Driver
    int        send_gap;
    coef_set_t cur_set;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs.valid  <= 1'b0;
            coefs.coef_a <= '0;
            coefs.coef_b <= '0;
            coefs.coef_c <= '0;
            send_gap     = 0;
        end
        else
        begin
            if (coefs.valid && coefs.ready)
            begin
                expected_roots.push_back(solve_roots(cur_set));
                n_sent++;
                send_gap = $urandom_range(0, 3);
                if ($urandom_range(0, 3) == 0)
                    send_gap = 0;
            end
            if (!coefs.valid || coefs.ready)
            begin
                if (send_gap > 0 || pending_sets.size() == 0)
                begin
                    if (send_gap > 0)
                        send_gap--;
                    coefs.valid <= 1'b0;
                end
                else
                begin
                    cur_set = pending_sets.pop_front();
                    coefs.valid  <= 1'b1;
                    coefs.coef_a <= cur_set.a;
                    coefs.coef_b <= cur_set.b;
                    coefs.coef_c <= cur_set.c;
                end
            end
        end
    end

    // Monitor
    int        stall_left;
    root_set_t want;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roots.ready <= 1'b0;
            stall_left  = 0;
        end
        else
        begin
            if (roots.valid && roots.ready)
            begin
                if (expected_roots.size() == 0)
                begin
                    $error("unexpected result beat: kind %0d", roots.root_kind);
                    errors++;
                end
                else
                begin
                    want = expected_roots.pop_front();
                    n_checked++;
                    kind_seen[want.kind]++;
                    if (roots.root_kind !== want.kind)
                    begin
                        $error("root_kind: expected %0d, actual %0d", want.kind, roots.root_kind);
                        errors++;
                    end
                    if (roots.root_high !== want.hi)
                    begin
                        $error("root_high: expected %0d, actual %0d", want.hi, roots.root_high);
                        errors++;
                    end
                    if (roots.root_low !== want.lo)
                    begin
                        $error("root_low: expected %0d, actual %0d", want.lo, roots.root_low);
                        errors++;
                    end
                end
                stall_left = $urandom_range(0, 3);
                if ($urandom_range(0, 3) == 0)
                    stall_left = 0;
            end
            if (hold_active)
                roots.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                roots.ready <= 1'b0;
            end
            else
                roots.ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        if ((coefs.valid && coefs.ready) || (roots.valid && roots.ready) || hold_active)
            idle_cycles = 0;
        else if (pending_sets.size() != 0 || expected_roots.size() != 0)
            idle_cycles++;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("watchdog expired with %0d results outstanding", expected_roots.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Long receiver hold-off so the pipe fills and back-pressures the input
    initial
    begin
        hold_active = 1'b0;
        wait (n_sent >= 400);
        @(posedge clk);
        hold_active = 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
        hold_active = 1'b0;
    end

    function automatic coef_set_t mk(input int a, input int b, input int c);
        coef_set_t s;
        s.a = CW'(a);
        s.b = CW'(b);
        s.c = CW'(c);
        return s;
    endfunction

    initial
    begin
        coef_set_t s;
        int        r;
        int        k;
        rst_n = 1'b0;

        pending_sets.push_back(mk(0, 0, 0));
        pending_sets.push_back(mk(0, 0, 7));
        pending_sets.push_back(mk(0, 3, 7));
        pending_sets.push_back(mk(0, -3, 7));
        pending_sets.push_back(mk(0, 1, -32768));
        pending_sets.push_back(mk(0, -32768, 32767));
        pending_sets.push_back(mk(1, 0, 1));
        pending_sets.push_back(mk(1, 2, 1));
        pending_sets.push_back(mk(-2, 4, -2));
        pending_sets.push_back(mk(5, 0, 0));
        pending_sets.push_back(mk(1, 0, -2));
        pending_sets.push_back(mk(-3, 0, 7));
        pending_sets.push_back(mk(1, -3, 2));
        pending_sets.push_back(mk(2, 5, -3));
        pending_sets.push_back(mk(1, -32768, -32768));
        pending_sets.push_back(mk(-32768, -32768, -32768));
        pending_sets.push_back(mk(32767, 32767, 32767));
        pending_sets.push_back(mk(1, -32768, 32767));
        pending_sets.push_back(mk(-32768, 32767, 32767));
        pending_sets.push_back(mk(1, 0, -32768));
        pending_sets.push_back(mk(-1, 32767, 0));
        for (int i = 0; i < N_RANDOM; i++)
        begin
            s.a = pick_coef();
            s.b = pick_coef();
            s.c = pick_coef();
            // every few sets, build a perfect square so the repeated-root path is hit
            if ($urandom_range(0, 9) == 0)
            begin
                r = $urandom_range(1, 90);
                k = $urandom_range(0, 200) - 100;
                s = mk(($urandom_range(0, 1) ? r : -r) * r, 2 * r * k, 0);
                s.c = CW'(s.a < 0 ? -k * k : k * k);
                s.b = CW'(s.a < 0 ? -2 * r * k : 2 * r * k);
            end
            pending_sets.push_back(s);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_sets.size() == 0 && expected_roots.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);

        $display("checked %0d root sets: %0d none, %0d linear, %0d two, %0d repeated, %0d no-real",
                 n_checked, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
        if (errors == 0 && expected_roots.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
